// ===== rtl/core/tbps_pkg.sv =====
// Shared types and constants for the token bucket packet shaper.
// No dependencies; used by every module of the shaper and its checker.
`default_nettype none

package tbps_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;

   localparam int ID_W     = 16;
   localparam int NEED_W   = 16;
   localparam int LEVEL_W  = 16;
   localparam int WAIT_W   = 7;
   localparam int STATUS_W = 3;

   localparam logic [LEVEL_W-1:0] DEPTH_RESET = 16'd10;

   // stream and register port widths
   localparam int REQ_TDATA_W = ID_W + NEED_W;                          // 32
   localparam int RSP_TDATA_W = 56;                                     // 55 bits used
   localparam int RSP_TUSER_W = STATUS_W + 1;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // register index, taken from paddr[2] (word address)
   localparam logic CSR_IDX_DEPTH = 1'b0;

   typedef enum logic {
      OP_TICK    = 1'b0,
      OP_ARRIVAL = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_TOKEN_ADDED      = 3'd0,
      ST_TOKEN_DROPPED    = 3'd1,
      ST_PACKET_QUEUED    = 3'd2,
      ST_DROPPED_OVERSIZE = 3'd3,
      ST_DROPPED_FULL     = 3'd4
   } status_type;

   typedef struct packed {
      logic [NEED_W-1:0] need;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/tbps_queue.sv =====
// Waiting-packet FIFO: memory with a registered head read and write forwarding.
// Depends on tbps_pkg.
`default_nettype none

module tbps_queue #(
   parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tbps_pkg::queue_ctl_type           ctl,
   input  wire tbps_pkg::entry_type               push_entry,
   output tbps_pkg::entry_type                    head_entry,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]       count
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

   tbps_pkg::entry_type mem [QUEUE_DEPTH];
   tbps_pkg::entry_type head_entry_ff;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (ctl.pop) begin
         head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + PTR_W'(1);
      end
      if (ctl.push) begin
         tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= push_entry;
      end
   end

   // read the next head; forward the entry written to that same slot this cycle
   always_ff @(posedge clock) begin
      if (ctl.push && (tail_ff == head_in)) begin
         head_entry_ff <= push_entry;
      end else begin
         head_entry_ff <= mem[head_in];
      end
   end

   assign head_entry = head_entry_ff;
   assign count      = count_ff;

endmodule

`default_nettype wire

// ===== rtl/core/token_bucket_packet_shaper.sv =====
// Token bucket packet shaper, top level: request register, event logic, result register.
// Depends on tbps_pkg and tbps_queue.
//
// Usage
//  - Request channel (req_*): one event per request. req_tuser is the operation
//    (0 token tick, 1 packet arrival); req_tdata carries packet id and token need.
//  - Result channel (rsp_*): exactly one result per request, in order. rsp_tuser
//    holds status and the release flag; rsp_tdata the released id and tokens,
//    bucket level and waiting count after the event.
//  - Config port (csr_*): APB-style, one register, bucket_depth at byte address 0.
//    Write it only while no request is in flight.
// Timing
//  - A request goes through the request register, then the result register;
//    one request per cycle is sustained while rsp_tready stays high: the event
//    logic is a single pass, and the head of the queue sits in a register read
//    ahead from the queue memory, so back-to-back events never wait on the
//    memory port.
// Reset and stall
//  - Synchronous reset empties the bucket and the queue and sets bucket_depth to 10.
//    Queue memory is not cleared; only written slots are ever read.
//  - When rsp_tready is low the result holds; the request register still drains
//    into a free result register, and req_tready drops only when both are full.
`default_nettype none

module token_bucket_packet_shaper #(
   parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [tbps_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [15:0] packet_id, [31:16] tokens_needed
   input  wire logic [0:0]                          req_tuser,  // [0] operation
   // result channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [tbps_pkg::RSP_TDATA_W-1:0]         rsp_tdata,  // [15:0] released_id,
                                                                // [31:16] released_tokens,
                                                                // [47:32] bucket_level,
                                                                // [54:48] waiting_count, [55] zero
   output logic [tbps_pkg::RSP_TUSER_W-1:0]         rsp_tuser,  // [2:0] status, [3] released
   // configuration port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [tbps_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [tbps_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tbps_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   // ---------------------------------------------------------------- config
   logic [tbps_pkg::LEVEL_W-1:0] depth_ff;
   logic                         csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == tbps_pkg::CSR_IDX_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= tbps_pkg::DEPTH_RESET;
      end else if (csr_write) begin
         depth_ff <= csr_pwdata[tbps_pkg::LEVEL_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == tbps_pkg::CSR_IDX_DEPTH) begin
         csr_prdata = {{(tbps_pkg::CSR_DATA_W - tbps_pkg::LEVEL_W){1'b0}}, depth_ff};
      end
   end

   // ---------------------------------------------------------- request register
   logic                          in_valid_ff, in_valid_in;
   tbps_pkg::op_type              in_op_ff;
   logic [tbps_pkg::ID_W-1:0]     in_id_ff;
   logic [tbps_pkg::NEED_W-1:0]   in_need_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          advance;
   logic                          req_take;

   // the event in the request register moves on when the result register is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= tbps_pkg::op_type'(req_tuser[0]);
         in_id_ff   <= req_tdata[tbps_pkg::ID_W-1:0];
         in_need_ff <= req_tdata[tbps_pkg::REQ_TDATA_W-1:tbps_pkg::ID_W];
      end
   end

   // ------------------------------------------------------------- event logic
   tbps_pkg::queue_ctl_type       q_ctl;
   tbps_pkg::entry_type           q_push_entry;
   tbps_pkg::entry_type           q_head;
   logic [CNT_W-1:0]              q_count;

   logic [tbps_pkg::LEVEL_W-1:0]  level_ff, level_in, level_mid;
   tbps_pkg::status_type          status;
   tbps_pkg::entry_type           head;
   logic                          oversize, full, enqueue, head_valid, release_head;
   logic [CNT_W-1:0]              count_after;

   always_comb begin
      oversize = in_need_ff > depth_ff;
      full     = q_count == FULL_COUNT;
      enqueue  = 1'b0;
      level_mid = level_ff;

      if (in_op_ff == tbps_pkg::OP_TICK) begin
         if (level_ff < depth_ff) begin
            level_mid = level_ff + tbps_pkg::LEVEL_W'(1);
            status    = tbps_pkg::ST_TOKEN_ADDED;
         end else begin
            status    = tbps_pkg::ST_TOKEN_DROPPED;
         end
      end else if (oversize) begin
         status = tbps_pkg::ST_DROPPED_OVERSIZE;
      end else if (full) begin
         status = tbps_pkg::ST_DROPPED_FULL;
      end else begin
         status  = tbps_pkg::ST_PACKET_QUEUED;
         enqueue = 1'b1;
      end

      q_push_entry.id   = in_id_ff;
      q_push_entry.need = in_need_ff;

      // an empty queue takes the arriving packet straight to the head
      head         = (q_count == '0) ? q_push_entry : q_head;
      head_valid   = (q_count != '0) || enqueue;
      release_head = head_valid && (head.need <= level_mid);

      level_in = release_head ? level_mid - head.need : level_mid;

      q_ctl.push = advance && enqueue;
      q_ctl.pop  = advance && release_head;

      count_after = q_count + CNT_W'(enqueue) - CNT_W'(release_head);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (advance) begin
         level_ff <= level_in;
      end
   end

   tbps_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctl        (q_ctl),
      .push_entry (q_push_entry),
      .head_entry (q_head),
      .count      (q_count)
   );

   // ----------------------------------------------------------- result register
   tbps_pkg::status_type           rsp_status_ff;
   logic                           rsp_released_ff;
   logic [tbps_pkg::ID_W-1:0]      rsp_id_ff;
   logic [tbps_pkg::NEED_W-1:0]    rsp_tokens_ff;
   logic [tbps_pkg::LEVEL_W-1:0]   rsp_level_ff;
   logic [tbps_pkg::WAIT_W-1:0]    rsp_wait_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff   <= status;
         rsp_released_ff <= release_head;
         rsp_id_ff       <= release_head ? head.id   : '0;
         rsp_tokens_ff   <= release_head ? head.need : '0;
         rsp_level_ff    <= level_in;
         rsp_wait_ff     <= tbps_pkg::WAIT_W'(count_after);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_released_ff, rsp_status_ff};
   assign rsp_tdata  = {1'b0, rsp_wait_ff, rsp_level_ff, rsp_tokens_ff, rsp_id_ff};

endmodule

`default_nettype wire

// ===== rtl/core/tbps_checker.sv =====
// Port-level checks on the token bucket packet shaper, bound to its top level.
// Depends on tbps_pkg and token_bucket_packet_shaper.
`default_nettype none

module tbps_checker #(
   parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic [tbps_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input wire logic [0:0]                          req_tuser,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [tbps_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input wire logic [tbps_pkg::RSP_TUSER_W-1:0]    rsp_tuser
);

   // a stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("request changed while stalled");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // reset leaves no result pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // no release: id and tokens read zero
   a_no_release_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[tbps_pkg::STATUS_W] |-> rsp_tdata[31:0] == 32'd0)
      else $error("released fields set without a release");

   // waiting count never exceeds the queue
   a_wait_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[54:48]) <= QUEUE_DEPTH)
      else $error("waiting count above queue depth");

endmodule

bind token_bucket_packet_shaper tbps_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tbps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== bench/token_bucket_packet_shaper_tb.sv =====
// Self-checking bench for the token bucket packet shaper: directed and random event streams.
// Depends on tbps_pkg and token_bucket_packet_shaper; keeps its own model of bucket and queue.
`default_nettype none

module token_bucket_packet_shaper_tb;
   import tbps_pkg::*;

   localparam int QDEPTH        = QUEUE_DEPTH_DEFAULT;
   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 8;     // extra wait once every result is back

   // register map
   localparam logic [CSR_ADDR_W-1:0] ADDR_BUCKET_DEPTH = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED     = 3'd4;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      status_type         status;
      logic               released;
      logic [ID_W-1:0]    rel_id;
      logic [NEED_W-1:0]  rel_tokens;
      logic [LEVEL_W-1:0] level;
      logic [WAIT_W-1:0]  waiting;
   } shaper_outcome_type;

   // clock, reset and block ports; every input starts at a known value
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_tvalid  = 1'b0;
   wire logic               req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata   = '0;
   logic [0:0]              req_tuser   = '0;
   wire logic               rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   wire logic [RSP_TDATA_W-1:0] rsp_tdata;
   wire logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   wire logic [CSR_DATA_W-1:0] csr_prdata;
   wire logic               csr_pready;

   token_bucket_packet_shaper u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // [15:0] packet_id, [31:16] tokens_needed
      .req_tuser   (req_tuser),   // [0] operation
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // [15:0] released_id, [31:16] released_tokens,
                                  // [47:32] bucket_level, [54:48] waiting_count
      .rsp_tuser   (rsp_tuser),   // [2:0] status, [3] released
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // ---------------------------------------------------------------------------
   // Shaper model: bucket fill, waiting-packet ring and the configured depth.
   // ---------------------------------------------------------------------------
   logic [LEVEL_W-1:0] depth_cfg   = DEPTH_RESET;
   logic [LEVEL_W-1:0] bucket_fill = '0;
   logic [ID_W-1:0]    slot_id   [QDEPTH];
   logic [NEED_W-1:0]  slot_need [QDEPTH];
   int                 rd_slot   = 0;
   int                 wr_slot   = 0;
   int                 n_waiting = 0;

   shaper_outcome_type shaper_outcomes[$];   // outcomes of accepted requests, oldest first
   int                 error_count = 0;

   // Outcome of one event; updates the model state as the block would.
   function automatic shaper_outcome_type shape_event(input op_type op,
                                                      input logic [ID_W-1:0] id,
                                                      input logic [NEED_W-1:0] need);
      shaper_outcome_type o;
      o.released   = 1'b0;
      o.rel_id     = '0;
      o.rel_tokens = '0;
      if (op == OP_TICK) begin
         // a bucket left above a lowered depth is not trimmed, the token is just lost
         if (bucket_fill < depth_cfg) begin
            bucket_fill = bucket_fill + 1'b1;
            o.status    = ST_TOKEN_ADDED;
         end else begin
            o.status = ST_TOKEN_DROPPED;
         end
      end else if (need > depth_cfg) begin
         o.status = ST_DROPPED_OVERSIZE;   // takes priority over a full queue
      end else if (n_waiting >= QDEPTH) begin
         o.status = ST_DROPPED_FULL;
      end else begin
         slot_id[wr_slot]   = id;
         slot_need[wr_slot] = need;
         wr_slot   = (wr_slot + 1) % QDEPTH;
         n_waiting = n_waiting + 1;
         o.status  = ST_PACKET_QUEUED;
      end
      // at most one release per event, head only
      if (n_waiting > 0 && slot_need[rd_slot] <= bucket_fill) begin
         bucket_fill  = bucket_fill - slot_need[rd_slot];
         o.released   = 1'b1;
         o.rel_id     = slot_id[rd_slot];
         o.rel_tokens = slot_need[rd_slot];
         rd_slot   = (rd_slot + 1) % QDEPTH;
         n_waiting = n_waiting - 1;
      end
      o.level   = bucket_fill;
      o.waiting = n_waiting[WAIT_W-1:0];
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // Idling control shared by the sender and the receiver process.
   // ---------------------------------------------------------------------------
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_off_req  = 0;   // set by a test, picked up by the receiver
   int hold_off_left = 0;

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 53;
            rsp_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            rsp_stall_pct = 53;
         end
         default: begin
            send_idle_pct = 7;
            rsp_stall_pct = 7;
         end
      endcase
   endtask

   // Receiver: random stalls, or a long counted hold-off when a test asks for one.
   always @(posedge clock) begin
      if (hold_off_req > 0) begin
         hold_off_left = hold_off_req;
         hold_off_req  = 0;
      end
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Result checker: every accepted result against the oldest outcome.
   // ---------------------------------------------------------------------------
   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t rsp %s mismatch: expected %0d actual %0d", $time, name, expected, actual);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      shaper_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (shaper_outcomes.size() == 0) begin
            $display("%0t rsp unexpected: expected none actual tuser %h tdata %h",
                     $time, rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = shaper_outcomes.pop_front();
            check_field("status",          int'(want.status),     int'(rsp_tuser[2:0]));
            check_field("released",        int'(want.released),   int'(rsp_tuser[3]));
            check_field("released_id",     int'(want.rel_id),     int'(rsp_tdata[15:0]));
            check_field("released_tokens", int'(want.rel_tokens), int'(rsp_tdata[31:16]));
            check_field("bucket_level",    int'(want.level),      int'(rsp_tdata[47:32]));
            check_field("waiting_count",   int'(want.waiting),    int'(rsp_tdata[54:48]));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Request side. tvalid stays high between back-to-back requests; it is only
   // lowered for an idle cycle or when a test stops sending.
   // ---------------------------------------------------------------------------
   task automatic send_event(input op_type op, input logic [ID_W-1:0] id,
                             input logic [NEED_W-1:0] need);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom();   // junk while idle
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {need, id};
      do @(posedge clock); while (!req_tready);
      shaper_outcomes.push_back(shape_event(op, id, need));
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_event(OP_TICK, ID_W'($urandom()), NEED_W'($urandom()));
   endtask

   // Stop sending and let every outstanding request come back.
   task automatic wait_drained;
      req_tvalid <= 1'b0;
      while (shaper_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, only with the block idle: setup cycle, then access cycle.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_BUCKET_DEPTH) depth_cfg = data[LEVEL_W-1:0];
   endtask

   // Empty the queue with ticks before the depth changes, so no head is left
   // needing more than the new depth.
   task automatic set_depth(input logic [LEVEL_W-1:0] depth);
      while (n_waiting > 0) send_ticks(1);
      write_csr(ADDR_BUCKET_DEPTH, {16'h0, depth});
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Basic event kinds at reset depth: zero need, oversize, head blocking, bucket cap.
   task automatic test_basic_events;
      set_idling(IDLE_NONE);
      send_event(OP_ARRIVAL, 16'h0000, 16'd0);      // zero need, released from an empty bucket
      send_event(OP_ARRIVAL, 16'hFFFF, 16'hFFFF);   // far oversize
      send_event(OP_ARRIVAL, 16'h1234, 16'd11);     // one above depth
      send_event(OP_TICK,    16'hFFFF, 16'hFFFF);   // tick fields ignored
      send_event(OP_ARRIVAL, 16'h0002, 16'd3);      // waits for tokens
      send_event(OP_ARRIVAL, 16'h0003, 16'd0);      // stuck behind the head
      send_ticks(3);                                // head, then zero-need packet leave
      send_ticks(11);                               // fills to depth, then drops
      send_event(OP_ARRIVAL, 16'h0004, 16'd10);     // exactly depth
   endtask

   // Depth lowered under the bucket fill and under a waiting head.
   task automatic test_lowered_depth;
      set_idling(IDLE_NONE);
      send_ticks(10);
      write_csr(ADDR_BUCKET_DEPTH, 32'd4);
      send_ticks(1);                                // bucket above depth: dropped, no trim
      send_event(OP_ARRIVAL, 16'h0010, 16'd3);
      send_ticks(1);
      send_event(OP_ARRIVAL, 16'h0011, 16'd4);
      send_ticks(1);
      send_event(OP_ARRIVAL, 16'h0012, 16'd5);      // oversize at depth 4
      write_csr(ADDR_BUCKET_DEPTH, 32'd10);
      send_event(OP_ARRIVAL, 16'h0013, 16'd9);      // queued, needs more than is there
      write_csr(ADDR_BUCKET_DEPTH, 32'd4);          // head now above depth
      send_ticks(1);
      send_event(OP_ARRIVAL, 16'h0014, 16'd1);      // blocked behind the head
      send_ticks(2);
      write_csr(ADDR_BUCKET_DEPTH, 32'd10);
      send_ticks(6);                                // head, then the one behind it
   endtask

   // Depth 0 and the top of the range, unmapped address, high data bits ignored.
   task automatic test_depth_extremes;
      set_idling(IDLE_NONE);
      write_csr(ADDR_BUCKET_DEPTH, 32'd0);
      send_ticks(1);
      send_event(OP_ARRIVAL, 16'h8001, 16'd0);
      send_event(OP_ARRIVAL, 16'h8002, 16'd1);
      write_csr(ADDR_UNMAPPED, 32'hFFFF_FFFF);      // no register there
      send_ticks(1);
      write_csr(ADDR_BUCKET_DEPTH, 32'hA5A5_FFFF);  // depth 65535
      send_ticks(3);
      send_event(OP_ARRIVAL, 16'h7FFE, 16'd2);
      write_csr(ADDR_BUCKET_DEPTH, 32'h0000_FFFE);
      send_event(OP_ARRIVAL, 16'h7FFF, 16'hFFFF);   // one above depth
   endtask

   // Fill the queue behind a blocked head, then overflow it.
   task automatic test_queue_full;
      set_idling(IDLE_NONE);
      set_depth(16'd10);
      send_event(OP_ARRIVAL, 16'hC000, 16'd10);
      for (int i = 1; i < QDEPTH; i++)
         send_event(OP_ARRIVAL, ID_W'($urandom()), NEED_W'($urandom_range(1)));
      send_event(OP_ARRIVAL, 16'hC0FE, 16'd5);      // queue full
      send_event(OP_ARRIVAL, 16'hC0FF, 16'd11);     // full and oversize: oversize reported
      while (n_waiting > 0) send_ticks(1);
   endtask

   task automatic send_random_event(input int arrival_pct);
      int r;
      int cap;
      r   = $urandom_range(99);
      cap = (depth_cfg < 12) ? int'(depth_cfg) : 12;
      if (r >= arrival_pct)
         send_ticks(1);
      else if (r < 4 && depth_cfg != 16'hFFFF)
         send_event(OP_ARRIVAL, ID_W'($urandom()),
                    NEED_W'($urandom_range(65535, int'(depth_cfg) + 1)));
      else
         send_event(OP_ARRIVAL, ID_W'($urandom()), NEED_W'($urandom_range(cap)));
   endtask

   // Output stalled for a long stretch while requests keep coming, then a pause
   // until every result is back, then traffic under random receiver stalls.
   task automatic test_backpressure;
      set_depth(16'd8);
      set_idling(IDLE_NONE);
      hold_off_req = 300;
      repeat (40) send_random_event(60);
      wait_drained();
      set_idling(IDLE_RECEIVER);
      repeat (20) send_random_event(60);
   endtask

   task automatic test_random_traffic(input logic [LEVEL_W-1:0] depth, input idle_mode_type mode,
                                      input int arrival_pct, input int count);
      set_depth(depth);
      set_idling(mode);
      repeat (count) send_random_event(arrival_pct);
   endtask

   // ---------------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------------
   int cycle_count = 0;

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_events();
      test_lowered_depth();
      test_depth_extremes();
      test_queue_full();
      test_backpressure();
      // the ticks that empty the queue before each depth change add to these counts
      test_random_traffic(16'd7,    IDLE_NONE,     50, 20);
      test_random_traffic(16'd1,    IDLE_SENDER,   55, 40);
      test_random_traffic(16'd16,   IDLE_RECEIVER, 80, 12);   // arrivals outpace tokens
      test_random_traffic(16'hFFFF, IDLE_BOTH,     45, 12);
      test_random_traffic(16'd3,    IDLE_BOTH,     50, 30);

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/tbps_pkg.sv
rtl/core/tbps_queue.sv
rtl/core/token_bucket_packet_shaper.sv
rtl/core/tbps_checker.sv
bench/token_bucket_packet_shaper_tb.sv
